@@ design/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// Deque package
// Shared constants, command and status codes and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int DEQ_CAPACITY  = 16;
  localparam int DEQ_WORD_BITS = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_PEEK       = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic shift_up;
    logic shift_dn;
    logic load_back;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/deq_cell.sv @@
// ----------------------------------------------------------------------------
// Deque storage cell
// Holds one entry, ordered by distance from the front, and trades words with
// its neighbors when the queue shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell #(
  parameter int WORD_BITS = deq_pkg::DEQ_WORD_BITS,
  parameter int CNT_W     = 5,
  parameter int POS       = 0
) (
  input  wire                    clk,
  input  deq_pkg::cell_ctrl_t    ctrl,
  input  wire  [CNT_W-1:0]       count_r,
  input  wire  [WORD_BITS-1:0]   push_word,
  input  wire  [WORD_BITS-1:0]   prev_word,
  input  wire  [WORD_BITS-1:0]   next_word,
  output logic [WORD_BITS-1:0]   data_r,
  output logic [WORD_BITS-1:0]   data_nxt
);

  localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_up) begin
      data_nxt = prev_word;
    end else if (ctrl.shift_dn) begin
      data_nxt = next_word;
    end else if (ctrl.load_back && (count_r == POS_C)) begin
      data_nxt = push_word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

@@ design/double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Bounded deque of signed words built as a row of shifting storage cells.
//
// Each input transfer carries one command in in_tdata: push front, push back,
// pop front, pop back, clear or peek (unused codes act as peek). Every
// command produces exactly one output transfer that reports the front and
// back words after the command (all ones when empty), the entry count, the
// empty and full flags and a status code (ok, overflow, underflow).
// Cell 0 always holds the front entry; a push or pop at the front shifts the
// whole row by one cell, and a push at the back writes the cell just past the
// last entry. The result is registered: output valid rises in the cycle after
// the input transfer, and the block takes one command per cycle while the
// receiver takes results. The output register accepts a new command in the
// same cycle its result is taken, so a stalled receiver stalls the input only
// while the registered result waits. Reset empties the queue and drops any
// pending result; stored words are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_top #(
  parameter int CAPACITY  = deq_pkg::DEQ_CAPACITY,
  parameter int WORD_BITS = deq_pkg::DEQ_WORD_BITS,
  parameter int CNT_W     = $clog2(CAPACITY + 1),
  parameter int IN_BITS   = ((deq_pkg::CMD_W + WORD_BITS + 7) / 8) * 8,
  parameter int OUT_BITS  = ((2 * WORD_BITS + CNT_W + 2 + deq_pkg::STATUS_W + 7) / 8) * 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  // Fields from bit 0: cmd, value.
  input  wire  [IN_BITS-1:0]  in_tdata,
  output logic                out_tvalid,
  input  wire                 out_tready,
  // Fields from bit 0: front_word, back_word, entry_count, is_empty,
  // is_full, status.
  output logic [OUT_BITS-1:0] out_tdata
);

  localparam int CMD_W    = deq_pkg::CMD_W;
  localparam int STATUS_W = deq_pkg::STATUS_W;
  localparam int PAY_BITS = 2 * WORD_BITS + CNT_W + 2 + STATUS_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic                   accept;
  deq_pkg::cmd_t          cmd;
  logic [WORD_BITS-1:0]   push_word;
  deq_pkg::cell_ctrl_t    ctrl;
  deq_pkg::status_t       status;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [WORD_BITS-1:0]   words_r   [CAPACITY];
  logic [WORD_BITS-1:0]   words_nxt [CAPACITY];
  logic [WORD_BITS-1:0]   back_sel;
  logic [WORD_BITS-1:0]   front_word;
  logic [WORD_BITS-1:0]   back_word;
  logic                   is_empty;
  logic                   is_full;
  logic                   out_tvalid_r;
  logic [PAY_BITS-1:0]    out_pay_r;
  logic [PAY_BITS-1:0]    out_pay_nxt;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_tvalid_r || out_tready;
  assign cmd       = deq_pkg::cmd_t'(in_tdata[CMD_W-1:0]);
  assign push_word = in_tdata[CMD_W +: WORD_BITS];

  always_comb begin
    ctrl      = '0;
    count_nxt = count_r;
    status    = deq_pkg::ST_OK;
    if (accept) begin
      case (cmd)
        deq_pkg::CMD_PUSH_FRONT: begin
          if (count_r == CAP_C) begin
            status = deq_pkg::ST_OVERFLOW;
          end else begin
            ctrl.shift_up = 1'b1;
            count_nxt     = CNT_W'(count_r + 1'b1);
          end
        end
        deq_pkg::CMD_PUSH_BACK: begin
          if (count_r == CAP_C) begin
            status = deq_pkg::ST_OVERFLOW;
          end else begin
            ctrl.load_back = 1'b1;
            count_nxt      = CNT_W'(count_r + 1'b1);
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (count_r == '0) begin
            status = deq_pkg::ST_UNDERFLOW;
          end else begin
            ctrl.shift_dn = 1'b1;
            count_nxt     = CNT_W'(count_r - 1'b1);
          end
        end
        deq_pkg::CMD_POP_BACK: begin
          if (count_r == '0) begin
            status = deq_pkg::ST_UNDERFLOW;
          end else begin
            count_nxt = CNT_W'(count_r - 1'b1);
          end
        end
        deq_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_BITS-1:0] prev_w;
      logic [WORD_BITS-1:0] next_w;
      if (g == 0) begin : g_first
        assign prev_w = push_word;
      end else begin : g_mid
        assign prev_w = words_r[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign next_w = words_r[g];
      end else begin : g_inner
        assign next_w = words_r[g+1];
      end
      deq_cell #(
        .WORD_BITS (WORD_BITS),
        .CNT_W     (CNT_W),
        .POS       (g)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .count_r   (count_r),
        .push_word (push_word),
        .prev_word (prev_w),
        .next_word (next_w),
        .data_r    (words_r[g]),
        .data_nxt  (words_nxt[g])
      );
    end
  endgenerate

  always_comb begin
    back_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (count_nxt == CNT_W'(i + 1)) begin
        back_sel = back_sel | words_nxt[i];
      end
    end
  end

  assign is_empty   = (count_nxt == '0);
  assign is_full    = (count_nxt == CAP_C);
  assign front_word = is_empty ? '1 : words_nxt[0];
  assign back_word  = is_empty ? '1 : back_sel;
  assign out_pay_nxt = {status, is_full, is_empty, count_nxt, back_word, front_word};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pay_r <= out_pay_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_BITS - PAY_BITS){1'b0}}, out_pay_r};

endmodule

`default_nettype wire

@@ design/deq_checker.sv @@
// ----------------------------------------------------------------------------
// Deque port checker
// Watches the top level's ports and checks the output handshake and the result fields for consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker #(
  parameter int CAPACITY  = deq_pkg::DEQ_CAPACITY,
  parameter int WORD_BITS = deq_pkg::DEQ_WORD_BITS,
  parameter int CNT_W     = $clog2(CAPACITY + 1),
  parameter int IN_BITS   = ((deq_pkg::CMD_W + WORD_BITS + 7) / 8) * 8,
  parameter int OUT_BITS  = ((2 * WORD_BITS + CNT_W + 2 + deq_pkg::STATUS_W + 7) / 8) * 8
) (
  input wire                clk,
  input wire                rst_n,
  input wire                in_tvalid,
  input wire                in_tready,
  input wire [IN_BITS-1:0]  in_tdata,
  input wire                out_tvalid,
  input wire                out_tready,
  input wire [OUT_BITS-1:0] out_tdata
);

  localparam int CNT_LSB = 2 * WORD_BITS;
  localparam int EMP_BIT = CNT_LSB + CNT_W;
  localparam int FUL_BIT = EMP_BIT + 1;
  localparam int ST_LSB  = FUL_BIT + 1;

  logic [WORD_BITS-1:0]        front_w;
  logic [WORD_BITS-1:0]        back_w;
  logic [CNT_W-1:0]            count;
  logic                        empty;
  logic                        full;
  logic [deq_pkg::STATUS_W-1:0] status;
  logic                        in_seen;

  assign front_w = out_tdata[0 +: WORD_BITS];
  assign back_w  = out_tdata[WORD_BITS +: WORD_BITS];
  assign count   = out_tdata[CNT_LSB +: CNT_W];
  assign empty   = out_tdata[EMP_BIT];
  assign full    = out_tdata[FUL_BIT];
  assign status  = out_tdata[ST_LSB +: deq_pkg::STATUS_W];
  assign in_seen = in_tvalid && in_tready && (in_tdata != '1 || in_tdata == '1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or dropped.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_seen |=> out_tvalid)
    else $error("Accepted command produced no result.");

  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (empty == (count == '0)) && (full == (count == CNT_W'(CAPACITY))))
    else $error("Empty or full flag disagrees with the entry count.");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && empty |-> (front_w == '1) && (back_w == '1))
    else $error("Empty queue reports words other than all ones.");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status == deq_pkg::ST_UNDERFLOW) |-> empty)
    else $error("Underflow reported on a non-empty queue.");

endmodule

bind double_ended_queue_top deq_checker #(
  .CAPACITY  (CAPACITY),
  .WORD_BITS (WORD_BITS),
  .CNT_W     (CNT_W),
  .IN_BITS   (IN_BITS),
  .OUT_BITS  (OUT_BITS)
) u_deq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
